/* rtl/ssms_pkg.sv */
// Shared types, codes and helpers for the SPI save-memory sequencer.
// No dependencies; compiled first.
package ssms_pkg;

  // Request commands
  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_SECTOR = 3'd2,
    CMD_CHIP   = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  // Chip types
  localparam logic [1:0] TYPE_NONE   = 2'd0;
  localparam logic [1:0] TYPE_SMALL  = 2'd1;
  localparam logic [1:0] TYPE_MEDIUM = 2'd2;
  localparam logic [1:0] TYPE_FLASH  = 2'd3;
  localparam logic [1:0] CHIP_TYPE_RST = TYPE_FLASH;

  // SPI opcodes
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_WRITE  = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] OP_SE     = 8'hD8;
  localparam logic [7:0] OP_CE     = 8'hC7;
  localparam logic [7:0] DUMMY     = 8'h00;
  localparam int         WIP_BIT   = 0;

  localparam int MAX_RES = 8;
  localparam int RES_IW  = $clog2(MAX_RES);
  localparam int RES_CW  = $clog2(MAX_RES + 1);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_WRITE = 4'b0010,
    PH_READ  = 4'b0100,
    PH_POLL  = 4'b1000
  } phase_t;

  // One SPI action (last_result is derived at the output)
  typedef struct packed {
    logic       send_byte;
    logic [7:0] spi_value;
    logic       deselect_after;
    logic       capture_read;
    logic       await_status;
    logic       op_done;
  } res_t;

  function automatic res_t mk_res(logic snd, logic [7:0] val, logic desel,
                                  logic cap, logic aw, logic done);
    res_t r;
    r.send_byte      = snd;
    r.spi_value      = val;
    r.deselect_after = desel;
    r.capture_read   = cap;
    r.await_status   = aw;
    r.op_done        = done;
    return r;
  endfunction

endpackage

/* rtl/ssms_if.sv */
// Valid/ready channel interfaces for the request and result sides.
// No package dependency.
interface ssms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [23:0] address;
  logic [7:0]  data_byte;
  logic        first_of_run;
  logic        last_of_run;

  modport source (output valid, command, address, data_byte, first_of_run,
                  last_of_run, input ready);
  modport sink   (input valid, command, address, data_byte, first_of_run,
                  last_of_run, output ready);
endinterface

interface ssms_out_if;
  logic       valid;
  logic       ready;
  logic       send_byte;
  logic [7:0] spi_value;
  logic       deselect_after;
  logic       capture_read;
  logic       await_status;
  logic       op_done;
  logic       last_result;

  modport source (output valid, send_byte, spi_value, deselect_after,
                  capture_read, await_status, op_done, last_result,
                  input ready);
  modport sink   (input valid, send_byte, spi_value, deselect_after,
                  capture_read, await_status, op_done, last_result,
                  output ready);
endinterface

/* rtl/spi_save_memory_sequencer_unit.sv */
// Top level of the SPI save-memory sequencer.
// Depends on ssms_pkg and the channel interfaces in ssms_if.sv.
//
// Turns byte-level save-memory requests into the SPI byte stream for a
// serial EEPROM or flash chip: reads, chunked writes (write enable before
// each chunk, status polling after it), sector and chip erase. Each
// accepted request is decoded into a list of up to eight SPI actions
// held in a result register, then handed out one action per cycle
// while the receiver is ready. The next request is taken in the same
// cycle as the last action of the previous one; a request yields at
// most 8 actions (write run start on flash with chunk close). Requests
// that do not fit the current phase yield no action.
// chip_type (reset 3) may only be written while no request is in flight.
module spi_save_memory_sequencer_unit #(
  parameter int TYPE1_CHUNK = 16,
  parameter int TYPE2_CHUNK = 128,
  parameter int TYPE3_CHUNK = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  ssms_in_if.sink          in_req,
  ssms_out_if.source       out_req
);

  // chunk sizes fit the 9-bit byte counter
  localparam logic [8:0] CHUNK1 = 9'(TYPE1_CHUNK);
  localparam logic [8:0] CHUNK2 = 9'(TYPE2_CHUNK);
  localparam logic [8:0] CHUNK3 = 9'(TYPE3_CHUNK);

  // sequencing state
  ssms_pkg::phase_t phase_r, phase_nxt;
  logic             frame_open_r, frame_open_nxt;
  logic [8:0]       chunk_cnt_r, chunk_cnt_nxt;
  logic             run_pend_r, run_pend_nxt;
  logic [1:0]       chip_type_r;

  // result list register and drain pointer
  ssms_pkg::res_t                  list_r [ssms_pkg::MAX_RES];
  ssms_pkg::res_t                  list_nxt [ssms_pkg::MAX_RES];
  logic [ssms_pkg::RES_CW-1:0]     cnt_r, n;
  logic [ssms_pkg::RES_IW-1:0]     idx_r;
  logic                            busy_r;

  logic       in_acc, out_take, at_last;
  logic [1:0] ty;
  logic [8:0] csize, cc_base, cc;
  logic       close;
  logic [7:0] hcode;

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  assign at_last  = ({1'b0, idx_r} == (cnt_r - ssms_pkg::RES_CW'(1)));
  assign out_take = busy_r & out_req.ready;
  assign in_req.ready = ~busy_r | (out_req.ready & at_last);
  assign in_acc   = in_req.valid & in_req.ready;

  // ------------------------------------------------------------------
  // decode: one request -> list of SPI actions and next state
  // ------------------------------------------------------------------
  assign ty = (chip_type_r == ssms_pkg::TYPE_NONE) ? ssms_pkg::TYPE_SMALL : chip_type_r;

  always_comb begin
    case (ty)
      ssms_pkg::TYPE_SMALL:  csize = CHUNK1;
      ssms_pkg::TYPE_MEDIUM: csize = CHUNK2;
      default:               csize = CHUNK3;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    frame_open_nxt = frame_open_r;
    chunk_cnt_nxt  = chunk_cnt_r;
    run_pend_nxt   = run_pend_r;
    n              = '0;
    cc_base        = chunk_cnt_r;
    cc             = '0;
    close          = 1'b0;
    hcode          = '0;
    for (int i = 0; i < ssms_pkg::MAX_RES; i++) begin
      list_nxt[i] = '0;
    end

    case (ssms_pkg::cmd_t'(in_req.command))
      ssms_pkg::CMD_WRITE: begin
        if ((phase_r == ssms_pkg::PH_IDLE && in_req.first_of_run) ||
            phase_r == ssms_pkg::PH_WRITE) begin
          if (phase_r == ssms_pkg::PH_IDLE || !frame_open_r) begin
            // new chunk: write enable, then program header
            list_nxt[n[ssms_pkg::RES_IW-1:0]] =
              ssms_pkg::mk_res(1'b1, ssms_pkg::OP_WREN, 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            hcode = ssms_pkg::OP_WRITE;
            if (ty == ssms_pkg::TYPE_SMALL) hcode[3] = in_req.address[8];
            list_nxt[n[ssms_pkg::RES_IW-1:0]] =
              ssms_pkg::mk_res(1'b1, hcode, 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            if (ty == ssms_pkg::TYPE_FLASH) begin
              list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
                in_req.address[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
              n = n + ssms_pkg::RES_CW'(1);
            end
            if (ty != ssms_pkg::TYPE_SMALL) begin
              list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
                in_req.address[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
              n = n + ssms_pkg::RES_CW'(1);
            end
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            frame_open_nxt = 1'b1;
            cc_base        = '0;
            phase_nxt      = ssms_pkg::PH_WRITE;
          end
          cc    = cc_base + 9'd1;
          close = in_req.last_of_run | (cc >= csize);
          list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
            in_req.data_byte, close, 1'b0, 1'b0, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          chunk_cnt_nxt = cc;
          if (close) begin
            run_pend_nxt = ~in_req.last_of_run;
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              ssms_pkg::OP_RDSR, 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              ssms_pkg::DUMMY, 1'b0, 1'b0, 1'b1, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            phase_nxt      = ssms_pkg::PH_POLL;
            frame_open_nxt = 1'b1;
            chunk_cnt_nxt  = '0;
          end
        end
      end

      ssms_pkg::CMD_READ: begin
        if (phase_r == ssms_pkg::PH_IDLE && in_req.first_of_run) begin
          hcode = ssms_pkg::OP_READ;
          if (ty == ssms_pkg::TYPE_SMALL) hcode[3] = in_req.address[8];
          list_nxt[n[ssms_pkg::RES_IW-1:0]] =
            ssms_pkg::mk_res(1'b1, hcode, 1'b0, 1'b0, 1'b0, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          if (ty == ssms_pkg::TYPE_FLASH) begin
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
          end
          if (ty != ssms_pkg::TYPE_SMALL) begin
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
          end
          list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
            in_req.address[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          phase_nxt      = ssms_pkg::PH_READ;
          frame_open_nxt = 1'b1;
        end
        if (phase_nxt == ssms_pkg::PH_READ) begin
          list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
            ssms_pkg::DUMMY, in_req.last_of_run, 1'b1, 1'b0, in_req.last_of_run);
          n = n + ssms_pkg::RES_CW'(1);
          if (in_req.last_of_run) begin
            phase_nxt      = ssms_pkg::PH_IDLE;
            frame_open_nxt = 1'b0;
          end
        end
      end

      ssms_pkg::CMD_SECTOR, ssms_pkg::CMD_CHIP: begin
        if (phase_r == ssms_pkg::PH_IDLE) begin
          list_nxt[n[ssms_pkg::RES_IW-1:0]] =
            ssms_pkg::mk_res(1'b1, ssms_pkg::OP_WREN, 1'b1, 1'b0, 1'b0, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          if (in_req.command == ssms_pkg::CMD_SECTOR) begin
            // sector erase always carries three address bytes
            list_nxt[n[ssms_pkg::RES_IW-1:0]] =
              ssms_pkg::mk_res(1'b1, ssms_pkg::OP_SE, 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              in_req.address[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
          end else begin
            list_nxt[n[ssms_pkg::RES_IW-1:0]] =
              ssms_pkg::mk_res(1'b1, ssms_pkg::OP_CE, 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
          end
          run_pend_nxt = 1'b0;
          list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
            ssms_pkg::OP_RDSR, 1'b0, 1'b0, 1'b0, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
            ssms_pkg::DUMMY, 1'b0, 1'b0, 1'b1, 1'b0);
          n = n + ssms_pkg::RES_CW'(1);
          phase_nxt      = ssms_pkg::PH_POLL;
          frame_open_nxt = 1'b1;
          chunk_cnt_nxt  = '0;
        end
      end

      ssms_pkg::CMD_STATUS: begin
        if (phase_r == ssms_pkg::PH_POLL) begin
          if (in_req.data_byte[ssms_pkg::WIP_BIT]) begin
            // still busy: clock out another status byte
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b1,
              ssms_pkg::DUMMY, 1'b0, 1'b0, 1'b1, 1'b0);
            n = n + ssms_pkg::RES_CW'(1);
          end else begin
            list_nxt[n[ssms_pkg::RES_IW-1:0]] = ssms_pkg::mk_res(1'b0,
              ssms_pkg::DUMMY, 1'b1, 1'b0, 1'b0, ~run_pend_r);
            n = n + ssms_pkg::RES_CW'(1);
            frame_open_nxt = 1'b0;
            chunk_cnt_nxt  = '0;
            phase_nxt      = run_pend_r ? ssms_pkg::PH_WRITE : ssms_pkg::PH_IDLE;
            run_pend_nxt   = 1'b0;
          end
        end
      end

      default: ;  // unused command codes are dropped
    endcase
  end

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_type_r <= ssms_pkg::CHIP_TYPE_RST;
    end else if (cfg_wr_en) begin
      chip_type_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ssms_pkg::PH_IDLE;
      frame_open_r <= 1'b0;
      chunk_cnt_r  <= '0;
      run_pend_r   <= 1'b0;
      busy_r       <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      frame_open_r <= frame_open_nxt;
      chunk_cnt_r  <= chunk_cnt_nxt;
      run_pend_r   <= run_pend_nxt;
      busy_r       <= (n != '0);
      cnt_r        <= n;
      idx_r        <= '0;
    end else if (out_take) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + ssms_pkg::RES_IW'(1);
      end
    end
  end

  // action list payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      list_r <= list_nxt;
    end
  end

  // ------------------------------------------------------------------
  // result channel
  // ------------------------------------------------------------------
  assign out_req.valid          = busy_r;
  assign out_req.send_byte      = list_r[idx_r].send_byte;
  assign out_req.spi_value      = list_r[idx_r].spi_value;
  assign out_req.deselect_after = list_r[idx_r].deselect_after;
  assign out_req.capture_read   = list_r[idx_r].capture_read;
  assign out_req.await_status   = list_r[idx_r].await_status;
  assign out_req.op_done        = list_r[idx_r].op_done;
  assign out_req.last_result    = at_last;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_busy_has_list: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("pending list is empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ssms_pkg::RES_CW'(ssms_pkg::MAX_RES))
    else $error("action count too large");

  a_accept_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && busy_r) |-> (out_req.ready && at_last))
    else $error("request accepted before list drained");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_req.op_done) |-> (phase_r == ssms_pkg::PH_IDLE && at_last))
    else $error("op_done while not idle or not last");

  a_poll_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ssms_pkg::PH_POLL) |-> frame_open_r)
    else $error("polling without open frame");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for spi_save_memory_sequencer_unit.
// Needs ssms_pkg (rtl/ssms_pkg.sv) and the channel interfaces in rtl/ssms_if.sv.
// Drives byte-level requests, predicts the SPI action stream, checks every action.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // chunk sizes of the three chip types, passed to the DUT as well
  localparam int SMALL_CHUNK  = 16;
  localparam int MEDIUM_CHUNK = 128;
  localparam int FLASH_CHUNK  = 256;

  // command code the block has no use for
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam int DRAIN_CYCLES   = 4;     // idle cycles before a register write
  localparam int TAIL_CYCLES    = 12;    // quiet cycles at the end of the run
  localparam int STALL_CYCLES   = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
  localparam int PHASE_TARGET   = 10;    // result-producing requests per random phase

  // one expected SPI action together with its end-of-request flag
  typedef struct packed {
    ssms_pkg::res_t action;
    logic           last_result;
  } spi_expect_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  ssms_in_if  in_bus ();
  ssms_out_if out_bus ();

  spi_save_memory_sequencer_unit #(
    .TYPE1_CHUNK (SMALL_CHUNK),
    .TYPE2_CHUNK (MEDIUM_CHUNK),
    .TYPE3_CHUNK (FLASH_CHUNK)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_bus),
    .out_req     (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Sequencer model: chip type register plus phase, frame and chunk state
  // ---------------------------------------------------------------------
  logic [1:0]        model_type;
  ssms_pkg::phase_t  model_phase;
  logic              frame_open;
  logic [8:0]        chunk_count;
  logic              run_pending;

  ssms_pkg::res_t step_actions[$];  // actions of the request being predicted
  spi_expect_t    spi_expected[$];  // actions still owed by the DUT

  int errors = 0;
  int productive_requests = 0;
  int ignored_requests = 0;
  int actions_checked = 0;

  // idle mix; read by the sender task and the receiver process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long stall handshake: tests bump stall_order, the receiver owns the count
  int stall_order = 0;
  int stall_seen = 0;
  int stall_left = 0;

  int quiet_cycles = 0;

  function automatic void add_action(logic snd, logic [7:0] val, logic desel, logic cap,
                                     logic aw, logic done);
    ssms_pkg::res_t a;
    a.send_byte      = snd;
    a.spi_value      = val;
    a.deselect_after = desel;
    a.capture_read   = cap;
    a.await_status   = aw;
    a.op_done        = done;
    step_actions.push_back(a);
  endfunction

  // opcode and address bytes; small eeprom folds address bit 8 into the opcode
  function automatic void add_header(logic [1:0] t, logic [23:0] addr, logic [7:0] op);
    logic [7:0] code;
    code = op;
    if (t == ssms_pkg::TYPE_SMALL) code[3] = code[3] | addr[8];
    add_action(1'b1, code, 1'b0, 1'b0, 1'b0, 1'b0);
    if (t == ssms_pkg::TYPE_FLASH) add_action(1'b1, addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
    if (t != ssms_pkg::TYPE_SMALL) add_action(1'b1, addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
    add_action(1'b1, addr[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  // read-status opcode then the first dummy poll byte
  function automatic void add_poll_start();
    add_action(1'b1, ssms_pkg::OP_RDSR, 1'b0, 1'b0, 1'b0, 1'b0);
    add_action(1'b1, ssms_pkg::DUMMY, 1'b0, 1'b0, 1'b1, 1'b0);
    model_phase = ssms_pkg::PH_POLL;
    frame_open  = 1'b1;
    chunk_count = '0;
  endfunction

  // Works out the actions one accepted request causes, queues them, returns the count.
  function automatic int predict_actions(logic [2:0] cmd, logic [23:0] addr, logic [7:0] data,
                                         logic first, logic last);
    logic [1:0]  t;
    int unsigned limit;
    logic        close;
    spi_expect_t e;
    step_actions.delete();
    t = (model_type == ssms_pkg::TYPE_NONE) ? ssms_pkg::TYPE_SMALL : model_type;
    limit = (t == ssms_pkg::TYPE_SMALL) ? SMALL_CHUNK :
            (t == ssms_pkg::TYPE_MEDIUM) ? MEDIUM_CHUNK : FLASH_CHUNK;
    case (cmd)
      ssms_pkg::CMD_WRITE: begin
        if ((model_phase == ssms_pkg::PH_IDLE && first) ||
            model_phase == ssms_pkg::PH_WRITE) begin
          // new chunk: write enable in its own frame, then program header
          if (model_phase == ssms_pkg::PH_IDLE || !frame_open) begin
            add_action(1'b1, ssms_pkg::OP_WREN, 1'b1, 1'b0, 1'b0, 1'b0);
            add_header(t, addr, ssms_pkg::OP_WRITE);
            frame_open  = 1'b1;
            chunk_count = '0;
            model_phase = ssms_pkg::PH_WRITE;
          end
          chunk_count = chunk_count + 9'd1;
          close = last || (chunk_count >= limit);
          add_action(1'b1, data, close, 1'b0, 1'b0, 1'b0);
          if (close) begin
            run_pending = !last;
            add_poll_start();
          end
        end
      end
      ssms_pkg::CMD_READ: begin
        if (model_phase == ssms_pkg::PH_IDLE && first) begin
          add_header(t, addr, ssms_pkg::OP_READ);
          model_phase = ssms_pkg::PH_READ;
          frame_open  = 1'b1;
        end
        if (model_phase == ssms_pkg::PH_READ) begin
          add_action(1'b1, ssms_pkg::DUMMY, last, 1'b1, 1'b0, last);
          if (last) begin
            model_phase = ssms_pkg::PH_IDLE;
            frame_open  = 1'b0;
          end
        end
      end
      ssms_pkg::CMD_SECTOR: begin
        if (model_phase == ssms_pkg::PH_IDLE) begin
          add_action(1'b1, ssms_pkg::OP_WREN, 1'b1, 1'b0, 1'b0, 1'b0);
          add_action(1'b1, ssms_pkg::OP_SE, 1'b0, 1'b0, 1'b0, 1'b0);
          add_action(1'b1, addr[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
          add_action(1'b1, addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
          add_action(1'b1, addr[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
          run_pending = 1'b0;
          add_poll_start();
        end
      end
      ssms_pkg::CMD_CHIP: begin
        if (model_phase == ssms_pkg::PH_IDLE) begin
          add_action(1'b1, ssms_pkg::OP_WREN, 1'b1, 1'b0, 1'b0, 1'b0);
          add_action(1'b1, ssms_pkg::OP_CE, 1'b1, 1'b0, 1'b0, 1'b0);
          run_pending = 1'b0;
          add_poll_start();
        end
      end
      ssms_pkg::CMD_STATUS: begin
        if (model_phase == ssms_pkg::PH_POLL) begin
          if (data[ssms_pkg::WIP_BIT]) begin
            add_action(1'b1, ssms_pkg::DUMMY, 1'b0, 1'b0, 1'b1, 1'b0);
          end else begin
            // poll over: release select, resume the write run or go idle
            add_action(1'b0, ssms_pkg::DUMMY, 1'b1, 1'b0, 1'b0, !run_pending);
            frame_open  = 1'b0;
            chunk_count = '0;
            if (run_pending) model_phase = ssms_pkg::PH_WRITE;
            else model_phase = ssms_pkg::PH_IDLE;
            run_pending = 1'b0;
          end
        end
      end
      default: ;
    endcase
    foreach (step_actions[i]) begin
      e.action      = step_actions[i];
      e.last_result = (i == step_actions.size() - 1);
      spi_expected.push_back(e);
    end
    return step_actions.size();
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Offers one request, waits for the handshake, then predicts its actions.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(input logic [2:0] cmd, input logic [23:0] addr,
                              input logic [7:0] data, input logic first, input logic last);
    int n;
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.address      <= addr;
    in_bus.data_byte    <= data;
    in_bus.first_of_run <= first;
    in_bus.last_of_run  <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n = predict_actions(cmd, addr, data, first, last);
    if (n == 0) ignored_requests++;
    else productive_requests++;
  endtask

  // Drops valid and waits until every predicted action has been seen.
  // Sampled at the falling edge so the result checker has already run.
  task automatic wait_drained(input int tail);
    in_bus.valid <= 1'b0;
    while (spi_expected.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_chip_type(input logic [1:0] value);
    wait_drained(DRAIN_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_type  = value;
  endtask

  // Answers status polls; busy about one time in three.
  task automatic answer_polls();
    logic [7:0] status;
    while (model_phase == ssms_pkg::PH_POLL) begin
      status = 8'($urandom);
      status[ssms_pkg::WIP_BIT] = ($urandom_range(2) == 0);
      send_request(ssms_pkg::CMD_STATUS, 24'($urandom), status,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic noise_request();
    send_request(3'($urandom_range(7)), 24'($urandom), 8'($urandom),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    answer_polls();
  endtask

  // Write run with random content; a few requests are noise, a few runs stay open.
  task automatic write_run(input int len, input bit start);
    logic [23:0] base;
    base = 24'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) noise_request();
      if ($urandom_range(29) == 0) set_chip_type(2'($urandom_range(3)));
      send_request(ssms_pkg::CMD_WRITE, base + 24'(i), 8'($urandom),
                   (i == 0 && start) ? 1'b1 : 1'($urandom_range(1)),
                   (i == len - 1) && ($urandom_range(9) != 0));
      answer_polls();
    end
  endtask

  task automatic read_run(input int len, input bit start);
    logic [23:0] base;
    base = 24'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) noise_request();
      send_request(ssms_pkg::CMD_READ, base + 24'(i), 8'($urandom),
                   (i == 0 && start) ? 1'b1 : 1'($urandom_range(1)),
                   (i == len - 1) && ($urandom_range(9) != 0));
    end
  endtask

  // Picks the next sequence from where the model stands.
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(99);
    case (model_phase)
      ssms_pkg::PH_POLL:  answer_polls();
      ssms_pkg::PH_WRITE: write_run($urandom_range(1, 20), 1'b0);
      ssms_pkg::PH_READ:  read_run($urandom_range(1, 6), 1'b0);
      default: begin
        if (pick < 40) write_run($urandom_range(1, 20), 1'b1);
        else if (pick < 65) read_run($urandom_range(1, 6), 1'b1);
        else if (pick < 75) begin
          send_request(ssms_pkg::CMD_SECTOR, 24'($urandom), 8'($urandom),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
          answer_polls();
        end else if (pick < 80) begin
          send_request(ssms_pkg::CMD_CHIP, 24'($urandom), 8'($urandom),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
          answer_polls();
        end else noise_request();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------
  // Receiver ready: random idling, or a long hold-off when a test orders one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_order != stall_seen) begin
      stall_seen = stall_order;
      stall_left = STALL_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Every accepted action is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    spi_expect_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (spi_expected.size() == 0) begin
        errors++;
        $display("%0t: SPI action with nothing expected, expected none actual value %0h",
                 $time, out_bus.spi_value);
      end else begin
        want = spi_expected.pop_front();
        actions_checked++;
        check_field("send_byte", 8'(want.action.send_byte), 8'(out_bus.send_byte));
        check_field("spi_value", want.action.spi_value, out_bus.spi_value);
        check_field("deselect_after", 8'(want.action.deselect_after),
                    8'(out_bus.deselect_after));
        check_field("capture_read", 8'(want.action.capture_read),
                    8'(out_bus.capture_read));
        check_field("await_status", 8'(want.action.await_status),
                    8'(out_bus.await_status));
        check_field("op_done", 8'(want.action.op_done), 8'(out_bus.op_done));
        check_field("last_result", 8'(want.last_result), 8'(out_bus.last_result));
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles, %0d actions outstanding",
                 $time, quiet_cycles, spi_expected.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Flash after reset: write run with busy poll, read, sector and chip erase.
  task automatic test_flash_requests();
    send_request(ssms_pkg::CMD_WRITE, 24'hFFFFFF, 8'hFF, 1'b1, 1'b0);
    send_request(ssms_pkg::CMD_WRITE, 24'h000000, 8'h00, 1'b0, 1'b1);
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h01, 1'b0, 1'b0);  // still busy
    send_request(ssms_pkg::CMD_STATUS, 24'hFFFFFF, 8'hFE, 1'b1, 1'b1);  // WIP clear
    send_request(ssms_pkg::CMD_READ, 24'h000000, 8'h00, 1'b1, 1'b1);
    send_request(ssms_pkg::CMD_SECTOR, 24'hABCDEF, 8'h00, 1'b0, 1'b0);
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
    send_request(ssms_pkg::CMD_CHIP, 24'h000000, 8'h00, 1'b0, 1'b0);
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
  endtask

  // Requests that do not fit the phase, plus first_of_run inside a run.
  task automatic test_ignored_requests();
    send_request(ssms_pkg::CMD_WRITE, 24'h123456, 8'h11, 1'b0, 1'b0);   // no run start
    send_request(ssms_pkg::CMD_READ, 24'h123456, 8'h22, 1'b0, 1'b1);    // no run start
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);  // not polling
    send_request(CMD_UNUSED, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1);
    send_request(ssms_pkg::CMD_READ, 24'h123456, 8'h00, 1'b1, 1'b0);
    send_request(ssms_pkg::CMD_WRITE, 24'h123457, 8'h33, 1'b1, 1'b0);   // write in read run
    send_request(ssms_pkg::CMD_SECTOR, 24'h123457, 8'h00, 1'b0, 1'b0);  // erase in read run
    send_request(ssms_pkg::CMD_STATUS, 24'h123457, 8'h00, 1'b0, 1'b0);
    send_request(ssms_pkg::CMD_READ, 24'h123458, 8'h00, 1'b1, 1'b0);    // first inside run
    send_request(ssms_pkg::CMD_READ, 24'h123459, 8'h00, 1'b0, 1'b1);
    send_request(ssms_pkg::CMD_WRITE, 24'h000100, 8'h5A, 1'b1, 1'b1);   // one-byte write
    send_request(ssms_pkg::CMD_READ, 24'h000000, 8'h00, 1'b1, 1'b1);    // read while polling
    send_request(ssms_pkg::CMD_WRITE, 24'h000000, 8'hA5, 1'b1, 1'b1);   // write while polling
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
  endtask

  // Addressing of the small and medium chip types, type zero handled as the small eeprom.
  task automatic test_chip_types();
    set_chip_type(ssms_pkg::TYPE_SMALL);
    send_request(ssms_pkg::CMD_READ, 24'h0001FF, 8'h00, 1'b1, 1'b1);    // bit 8 into opcode
    send_request(ssms_pkg::CMD_WRITE, 24'h000100, 8'h5A, 1'b1, 1'b1);
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
    set_chip_type(ssms_pkg::TYPE_NONE);
    send_request(ssms_pkg::CMD_WRITE, 24'hFFFEFF, 8'hC3, 1'b1, 1'b1);
    send_request(ssms_pkg::CMD_STATUS, 24'h000000, 8'h00, 1'b0, 1'b0);
    set_chip_type(ssms_pkg::TYPE_MEDIUM);
    send_request(ssms_pkg::CMD_READ, 24'hFEDCBA, 8'h00, 1'b1, 1'b1);
    set_chip_type(ssms_pkg::TYPE_FLASH);
  endtask

  // Receiver holds off while a small eeprom write run keeps coming, so the block
  // fills and stalls its input. 16 bytes close a full chunk, then the last byte
  // reopens a chunk and closes it at once.
  task automatic test_long_stall();
    logic [23:0] base;
    base = 24'($urandom);
    set_chip_type(ssms_pkg::TYPE_SMALL);
    stall_order++;
    for (int i = 0; i < SMALL_CHUNK + 1; i++) begin
      send_request(ssms_pkg::CMD_WRITE, base + 24'(i), 8'($urandom),
                   i == 0, i == SMALL_CHUNK);
      answer_polls();
    end
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct, input bit long_run);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = productive_requests;
    // one run long enough to fill a small eeprom chunk
    if (long_run) begin
      set_chip_type(ssms_pkg::TYPE_SMALL);
      write_run(SMALL_CHUNK + 4, 1'b1);
    end
    while (productive_requests - start < PHASE_TARGET) begin
      if ($urandom_range(4) == 0) set_chip_type(2'($urandom_range(3)));
      random_sequence();
    end
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.command      = ssms_pkg::CMD_WRITE;
    in_bus.address      = '0;
    in_bus.data_byte    = '0;
    in_bus.first_of_run = 1'b0;
    in_bus.last_of_run  = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = ssms_pkg::TYPE_FLASH;
    model_type          = ssms_pkg::CHIP_TYPE_RST;
    model_phase         = ssms_pkg::PH_IDLE;
    frame_open          = 1'b0;
    chunk_count         = '0;
    run_pending         = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 70;
    test_flash_requests();
    test_ignored_requests();
    test_chip_types();
    test_long_stall();

    run_random_phase(13, 70, 1'b0);
    run_random_phase(70, 13, 1'b1);
    run_random_phase(0, 0, 1'b0);

    wait_drained(TAIL_CYCLES);

    $display("Covered %0d requests with results and %0d ignored, %0d SPI actions checked,",
             productive_requests, ignored_requests, actions_checked);
    $display("over chip types 0 to 3, three idle mixes and a %0d-cycle receiver stall",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* spi_save_memory_sequencer_unit.f */
rtl/ssms_pkg.sv
rtl/ssms_if.sv
rtl/spi_save_memory_sequencer_unit.sv
dv/testbench.sv
